[sv/two_axis_stepper_move_with_limits_unit_macros.svh]
// Assertion macros for the two-axis stepper unit.
`ifndef TWO_AXIS_STEPPER_MOVE_WITH_LIMITS_UNIT_MACROS_SVH
`define TWO_AXIS_STEPPER_MOVE_WITH_LIMITS_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define TASM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define TASM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/tasm_pkg.sv]
// Package: types and constants of the two-axis stepper unit.
`timescale 1ns / 1ps
`default_nettype none
package tasm_pkg;

    localparam int POSITION_BITS_DEF = 16;

    localparam int DELTA_W   = 16;
    localparam int POS_OUT_W = 16;
    localparam int POS_MIN_W = 16;
    localparam int POS_MAX_W = 15;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [POS_MIN_W-1:0] POS_MIN_RST = 16'hFB6C;  // -1172
    localparam logic [POS_MAX_W-1:0] POS_MAX_RST = 15'd1172;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_MAX = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_HOME = 2'd2,
        OP_CAL  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_MOVE = 2'd1,
        MODE_CALX = 2'd2,
        MODE_CALY = 2'd3
    } t_mode;

endpackage
`default_nettype wire

[sv/two_axis_stepper_move_with_limits_unit.sv]
// Top level: two-axis step generator with position tracking and soft limits.
//
//  channel   direction  handshake                   payload
//  in        sink       i_in_valid / o_in_ready     operation, delta_x/y, endstop_x/y
//  out       source     o_out_valid / i_out_ready   pulses, directions, busy, fault, pos
//  cfg       sink       i_cfg_we                    i_cfg_index, i_cfg_data
//
// One item per cycle while o_in_ready is high; the result follows in the next cycle.
// State and result register update together at the accepting edge.
// o_in_ready is high whenever the result register is empty or being taken.
// Synchronous active-low reset; the limits return to -1172 / 1172.
`timescale 1ns / 1ps
`default_nettype none
module two_axis_stepper_move_with_limits_unit #(
    parameter int POSITION_BITS = tasm_pkg::POSITION_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_operation,
    input  wire logic [tasm_pkg::DELTA_W-1:0]   i_delta_x,
    input  wire logic [tasm_pkg::DELTA_W-1:0]   i_delta_y,
    input  wire logic                           i_endstop_x,
    input  wire logic                           i_endstop_y,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic                                o_pulse_x,
    output logic                                o_pulse_y,
    output logic                                o_direction_x,
    output logic                                o_direction_y,
    output logic                                o_busy_res,
    output logic                                o_limit_fault,
    output logic [tasm_pkg::POS_OUT_W-1:0]      o_position_x,
    output logic [tasm_pkg::POS_OUT_W-1:0]      o_position_y,
    input  wire logic                           i_cfg_we,
    input  wire logic [tasm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [tasm_pkg::CFG_W-1:0]     i_cfg_data
);
    import tasm_pkg::*;

    localparam int P  = POSITION_BITS;
    localparam int MW = (P > DELTA_W) ? P : DELTA_W;
    localparam int CW = MW + 1;

    localparam logic [P-1:0] PMAX_P = {1'b0, {(P-1){1'b1}}};
    localparam logic [P-1:0] PMIN_P = {1'b1, {(P-1){1'b0}}};
    localparam logic signed [CW-1:0] PMIN_C = $signed({{(CW-P+1){1'b1}}, {(P-1){1'b0}}});
    localparam logic [MW-1:0] RMAX_M = MW'({P{1'b1}});

    // configuration
    logic [POS_MIN_W-1:0] r_pos_min;
    logic [POS_MAX_W-1:0] r_pos_max;

    // state
    t_mode               r_mode, n_mode;
    logic                r_fault, n_fault;
    logic signed [P-1:0] r_pos_x, n_pos_x, r_pos_y, n_pos_y;
    logic [P-1:0]        r_rem_x, n_rem_x, r_rem_y, n_rem_y;
    logic                r_dir_x, n_dir_x, r_dir_y, n_dir_y;
    logic                n_pulse_x, n_pulse_y;

    // result register
    logic                 r_out_valid;
    logic                 r_pulse_x, r_pulse_y, r_dir_res_x, r_dir_res_y;
    logic                 r_busy_res, r_fault_res;
    logic [POS_OUT_W-1:0] r_pos_res_x, r_pos_res_y;

    logic in_accept;

    // limits and helpers
    logic signed [CW-1:0] lo_c, hi_c, lo_clamp;
    logic signed [P-1:0]  cal_pos;
    logic                 nz_x, nz_y, edge_x, edge_y, bad;
    logic signed [P-1:0]  mv_pos_x, mv_pos_y;
    logic signed [CW-1:0] mv_c_x, mv_c_y;
    logic signed [CW-1:0] out_c_x, out_c_y;

    // move load from deltas
    logic [DELTA_W-1:0] mag_dx, mag_dy;
    logic [MW-1:0]      mag_ext_x, mag_ext_y;
    logic [P-1:0]       ld_rem_x, ld_rem_y;
    // return-home load
    logic [P-1:0]       hm_rem_x, hm_rem_y;
    logic               hm_dir_x, hm_dir_y;

    assign in_accept  = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;

    assign lo_c     = CW'($signed(r_pos_min));
    assign hi_c     = CW'($signed({1'b0, r_pos_max}));
    assign lo_clamp = (lo_c < PMIN_C) ? PMIN_C : lo_c;
    assign cal_pos  = lo_clamp[P-1:0];

    assign nz_x   = |r_rem_x;
    assign nz_y   = |r_rem_y;
    assign edge_x = r_dir_x ? (r_pos_x == PMAX_P) : (r_pos_x == PMIN_P);
    assign edge_y = r_dir_y ? (r_pos_y == PMAX_P) : (r_pos_y == PMIN_P);

    assign mv_pos_x = (nz_x && !edge_x) ? (r_pos_x + (r_dir_x ? P'(1) : '1)) : r_pos_x;
    assign mv_pos_y = (nz_y && !edge_y) ? (r_pos_y + (r_dir_y ? P'(1) : '1)) : r_pos_y;
    assign mv_c_x   = CW'(mv_pos_x);
    assign mv_c_y   = CW'(mv_pos_y);

    assign bad = (nz_x && edge_x) || (nz_y && edge_y)
              || (mv_c_x < lo_c) || (mv_c_x > hi_c)
              || (mv_c_y < lo_c) || (mv_c_y > hi_c);

    assign mag_dx    = i_delta_x[DELTA_W-1] ? (~i_delta_x + 1'b1) : i_delta_x;
    assign mag_dy    = i_delta_y[DELTA_W-1] ? (~i_delta_y + 1'b1) : i_delta_y;
    assign mag_ext_x = MW'(mag_dx);
    assign mag_ext_y = MW'(mag_dy);
    assign ld_rem_x  = (mag_ext_x > RMAX_M) ? '1 : mag_ext_x[P-1:0];
    assign ld_rem_y  = (mag_ext_y > RMAX_M) ? '1 : mag_ext_y[P-1:0];

    assign hm_dir_x = r_pos_x[P-1] || (r_pos_x == '0);
    assign hm_dir_y = r_pos_y[P-1] || (r_pos_y == '0);
    assign hm_rem_x = r_pos_x[P-1] ? (~r_pos_x + 1'b1) : r_pos_x;
    assign hm_rem_y = r_pos_y[P-1] ? (~r_pos_y + 1'b1) : r_pos_y;

    always_comb begin
        n_mode    = r_mode;
        n_fault   = r_fault;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_rem_x   = r_rem_x;
        n_rem_y   = r_rem_y;
        n_dir_x   = r_dir_x;
        n_dir_y   = r_dir_y;
        n_pulse_x = 1'b0;
        n_pulse_y = 1'b0;
        if (t_op'(i_operation) == OP_TICK) begin
            unique case (r_mode)
                MODE_MOVE: begin
                    n_pulse_x = nz_x;
                    n_pulse_y = nz_y;
                    n_pos_x   = mv_pos_x;
                    n_pos_y   = mv_pos_y;
                    if (bad) begin
                        n_rem_x = '0;
                        n_rem_y = '0;
                        n_fault = 1'b1;
                        n_mode  = MODE_IDLE;
                    end else begin
                        n_rem_x = nz_x ? (r_rem_x - 1'b1) : r_rem_x;
                        n_rem_y = nz_y ? (r_rem_y - 1'b1) : r_rem_y;
                        if (r_rem_x <= P'(1) && r_rem_y <= P'(1)) begin
                            n_mode = MODE_IDLE;
                        end
                    end
                end
                MODE_CALX: begin
                    n_pulse_x = 1'b1;
                    if (!i_endstop_x) begin
                        n_mode = MODE_CALY;
                    end
                end
                MODE_CALY: begin
                    n_pulse_y = 1'b1;
                    if (!i_endstop_y) begin
                        n_pos_x = cal_pos;
                        n_pos_y = cal_pos;
                        n_mode  = MODE_IDLE;
                    end
                end
                MODE_IDLE: begin
                end
            endcase
        end else if (r_mode == MODE_IDLE) begin
            n_fault = 1'b0;
            unique case (t_op'(i_operation))
                OP_MOVE: begin
                    n_rem_x = ld_rem_x;
                    n_rem_y = ld_rem_y;
                    n_dir_x = !i_delta_x[DELTA_W-1];
                    n_dir_y = !i_delta_y[DELTA_W-1];
                    n_mode  = MODE_MOVE;
                end
                OP_HOME: begin
                    n_rem_x = hm_rem_x;
                    n_rem_y = hm_rem_y;
                    n_dir_x = hm_dir_x;
                    n_dir_y = hm_dir_y;
                    n_mode  = MODE_MOVE;
                end
                OP_CAL: begin
                    n_rem_x = '0;
                    n_rem_y = '0;
                    n_dir_x = 1'b0;
                    n_dir_y = 1'b0;
                    n_mode  = MODE_CALX;
                end
                OP_TICK: begin
                end
            endcase
        end
    end

    assign out_c_x = CW'(n_pos_x);
    assign out_c_y = CW'(n_pos_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_min <= POS_MIN_RST;
            r_pos_max <= POS_MAX_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_POS_MIN: r_pos_min <= i_cfg_data[POS_MIN_W-1:0];
                CFG_POS_MAX: r_pos_max <= i_cfg_data[POS_MAX_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_fault <= 1'b0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_rem_x <= '0;
            r_rem_y <= '0;
            r_dir_x <= 1'b0;
            r_dir_y <= 1'b0;
        end else if (in_accept) begin
            r_mode  <= n_mode;
            r_fault <= n_fault;
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_dir_x <= n_dir_x;
            r_dir_y <= n_dir_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pulse_x   <= n_pulse_x;
            r_pulse_y   <= n_pulse_y;
            r_dir_res_x <= n_dir_x;
            r_dir_res_y <= n_dir_y;
            r_busy_res  <= (n_mode != MODE_IDLE);
            r_fault_res <= n_fault;
            r_pos_res_x <= out_c_x[POS_OUT_W-1:0];
            r_pos_res_y <= out_c_y[POS_OUT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pulse_x     = r_pulse_x;
    assign o_pulse_y     = r_pulse_y;
    assign o_direction_x = r_dir_res_x;
    assign o_direction_y = r_dir_res_y;
    assign o_busy_res    = r_busy_res;
    assign o_limit_fault = r_fault_res;
    assign o_position_x  = r_pos_res_x;
    assign o_position_y  = r_pos_res_y;

`include "two_axis_stepper_move_with_limits_unit_macros.svh"

    `TASM_ASSERT_IMP(a_idle_no_steps, r_mode == MODE_IDLE, r_rem_x == '0 && r_rem_y == '0, "idle with steps left")
    `TASM_ASSERT_IMP(a_fault_idle, r_fault, r_mode == MODE_IDLE, "fault while busy")
    `TASM_ASSERT_IMP(a_cal_negative, r_mode == MODE_CALX || r_mode == MODE_CALY, !r_dir_x && !r_dir_y, "calibration not toward minimum")
    `TASM_ASSERT_IMP(a_busy_tracks, r_out_valid, r_busy_res == (r_mode != MODE_IDLE), "busy result disagrees with mode")
    `TASM_ASSERT_NXT(a_move_pulses, in_accept && t_op'(i_operation) == OP_TICK && r_mode == MODE_MOVE && nz_x, r_pulse_x, "missing X pulse")

endmodule
`default_nettype wire
